/* sv/mprc_pkg.sv */
// ----------------------------------------------------------------------------
// mprc_pkg
// Shared sizes and types of the MED predictor residual codec.
// ----------------------------------------------------------------------------
package mprc_pkg;

  // line buffer depth, in pixels
  localparam int MAX_WIDTH = 2048;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int IMG_W_W   = 12;
  localparam int IMG_H_W   = 16;
  // width wide enough for the width register and for MAX_WIDTH itself
  localparam int WW        = (COL_W + 1 > IMG_W_W) ? COL_W + 1 : IMG_W_W;

  localparam int CHAN_W    = 8;
  localparam int NCHAN     = 4;
  localparam int PIX_W     = CHAN_W * NCHAN;

  // register indexes, one 32-bit register per word address
  typedef enum logic [1:0] {
    REG_MODE   = 2'd0,
    REG_DECODE = 2'd1,
    REG_WIDTH  = 2'd2,
    REG_HEIGHT = 2'd3
  } reg_idx_t;

  // per-item control handed to the channel datapaths
  typedef struct packed {
    logic first;     // first pixel of the image, passes through raw
    logic col0;      // column zero, predict from up
    logic use_left;  // row zero or left predictor mode
    logic decode;    // rebuild pixels from residuals
  } chan_ctl_t;

endpackage

/* sv/mprc_ram.sv */
// ----------------------------------------------------------------------------
// mprc_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mprc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/mprc_chan.sv */
// ----------------------------------------------------------------------------
// mprc_chan
// One color channel: prediction from the neighbors, then residual or rebuild.
// ----------------------------------------------------------------------------
module mprc_chan
  import mprc_pkg::*;
(
  input  chan_ctl_t         ctl,
  input  logic [CHAN_W-1:0] x,         // pixel or residual magnitude
  input  logic              sign_in,   // decode sign, 1 means subtract
  input  logic [CHAN_W-1:0] nb_left,
  input  logic [CHAN_W-1:0] nb_up,
  input  logic [CHAN_W-1:0] nb_ul,
  output logic [CHAN_W-1:0] res,
  output logic              sign_out,
  output logic [CHAN_W-1:0] pix        // true or rebuilt pixel for the neighbors
);

  logic [CHAN_W-1:0] mx;
  logic [CHAN_W-1:0] mn;
  logic [CHAN_W-1:0] med;
  logic [CHAN_W-1:0] pred;

  // median edge detector
  always_comb begin
    mx = (nb_left > nb_up) ? nb_left : nb_up;
    mn = (nb_left > nb_up) ? nb_up : nb_left;
    if (nb_ul >= mx) begin
      med = mn;
    end else if (nb_ul <= mn) begin
      med = mx;
    end else begin
      med = nb_left + nb_up - nb_ul;
    end
  end

  // predictor select
  always_comb begin
    if (ctl.col0) begin
      pred = nb_up;
    end else if (ctl.use_left) begin
      pred = nb_left;
    end else begin
      pred = med;
    end
  end

  // residual or rebuild
  always_comb begin
    res      = x;
    sign_out = 1'b0;
    pix      = x;
    if (ctl.first) begin
      res = x;
    end else if (ctl.decode) begin
      res = sign_in ? (pred - x) : (pred + x);
      pix = res;
    end else if (x > pred) begin
      res = x - pred;
    end else begin
      res      = pred - x;
      sign_out = 1'b1;
    end
  end

endmodule

/* sv/med_predictor_residual_codec.sv */
// ----------------------------------------------------------------------------
// med_predictor_residual_codec
// RGBA pixel stream residual encoder / decoder with left/up or MED predictor.
// ----------------------------------------------------------------------------
// Usage:
//   in_* takes RGBA items in raster order (channels or residual magnitudes
//   plus decode signs); out_* gives the residuals with their signs (encode)
//   or the rebuilt pixel (decode), with out_tlast on the last pixel of the
//   image. cfg_* is an APB register port, to be written only while idle; the
//   block does not enforce this. Throughput is one item per clock while
//   out_tready holds. An item passes the compute stage register, where
//   prediction works, then the output register. The line buffer read is
//   issued at the accepting edge (one RAM read port, one write port).
//   The previous row lives in a MAX_WIDTH x 32 RAM; a pixel written back in
//   the same cycle that the next item reads its entry is forwarded.
//   Reset clears the counters, the neighbor registers and both valid flags;
//   the line buffer is not cleared, its data is only used once written.
//   When out_tready is low the result waits in the output register, one
//   more item is taken into the compute stage, and in_tready then drops
//   until the output register drains.
// ----------------------------------------------------------------------------
module med_predictor_residual_codec
  import mprc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input items
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // value_r, value_g, value_b, value_a, sign_bits, 4'b0
  // result items
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // out_r, out_g, out_b, out_a, out_signs, 4'b0
  output logic        out_tlast,  // end_of_image
  // register port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  // configuration registers
  logic               mode_r;
  logic               decode_r;
  logic [IMG_W_W-1:0] width_r;
  logic [IMG_H_W-1:0] height_r;

  // issue counters
  logic [COL_W-1:0]   col_r;
  logic [COL_W-1:0]   col_nxt;
  logic [IMG_H_W-1:0] row_r;
  logic [IMG_H_W-1:0] row_nxt;

  // compute stage
  logic               s1_valid_r;
  logic [PIX_W-1:0]   s1_x_r;
  logic [NCHAN-1:0]   s1_sin_r;
  chan_ctl_t          s1_ctl_r;
  logic               s1_eoi_r;
  logic [COL_W-1:0]   s1_col_r;
  logic               s1_fwd_r;

  // neighbors
  logic [PIX_W-1:0]   left_r;
  logic [PIX_W-1:0]   ul_r;
  logic [PIX_W-1:0]   ram_rdata;
  logic [PIX_W-1:0]   up;

  // output register
  logic               out_valid_r;
  logic [39:0]        out_data_r;
  logic               out_last_r;

  logic               in_acc;
  logic               s1_adv;
  logic               cfg_wr;
  reg_idx_t           cfg_idx;
  logic [WW-1:0]      w_raw;
  logic [WW-1:0]      w_eff;
  logic [WW-1:0]      col_inc;
  logic [IMG_H_W-1:0] h_eff;
  logic [IMG_H_W:0]   row_inc;
  logic               row_end;
  logic               img_end;
  chan_ctl_t          ctl_nxt;
  logic               fwd_nxt;
  logic [PIX_W-1:0]   res;
  logic [PIX_W-1:0]   pix;
  logic [NCHAN-1:0]   signs;

  // handshakes
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_wr    = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx   = reg_idx_t'(cfg_paddr[3:2]);
  assign cfg_pready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= 1'b1;
      decode_r <= 1'b0;
      width_r  <= IMG_W_W'(2048);
      height_r <= IMG_H_W'(1);
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_MODE:   mode_r   <= cfg_pwdata[0];
        REG_DECODE: decode_r <= cfg_pwdata[0];
        REG_WIDTH:  width_r  <= cfg_pwdata[IMG_W_W-1:0];
        REG_HEIGHT: height_r <= cfg_pwdata[IMG_H_W-1:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    case (cfg_idx)
      REG_MODE:   cfg_prdata = {31'd0, mode_r};
      REG_DECODE: cfg_prdata = {31'd0, decode_r};
      REG_WIDTH:  cfg_prdata = {{(32-IMG_W_W){1'b0}}, width_r};
      REG_HEIGHT: cfg_prdata = {{(32-IMG_H_W){1'b0}}, height_r};
      default:    cfg_prdata = 32'd0;
    endcase
  end

  // effective image size and raster position step
  always_comb begin
    w_raw   = WW'(width_r);
    if (w_raw == '0) begin
      w_eff = WW'(1);
    end else if (w_raw > WW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = w_raw;
    end
    h_eff   = (height_r == '0) ? IMG_H_W'(1) : height_r;
    col_inc = WW'(col_r) + WW'(1);
    row_inc = {1'b0, row_r} + (IMG_H_W+1)'(1);
    row_end = col_inc >= w_eff;
    img_end = row_end && (row_inc >= {1'b0, h_eff});
    col_nxt = row_end ? '0 : col_inc[COL_W-1:0];
    if (!row_end) begin
      row_nxt = row_r;
    end else if (img_end) begin
      row_nxt = '0;
    end else begin
      row_nxt = row_inc[IMG_H_W-1:0];
    end
    ctl_nxt.first    = (col_r == '0) && (row_r == '0);
    ctl_nxt.col0     = (col_r == '0);
    ctl_nxt.use_left = (row_r == '0) || !mode_r;
    ctl_nxt.decode   = decode_r;
    // the entry being read is written back at this same edge
    fwd_nxt = s1_adv && (s1_col_r == col_r);
  end

  // issue counters and compute stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  // compute stage payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_x_r   <= in_tdata[PIX_W-1:0];
      s1_sin_r <= in_tdata[PIX_W+NCHAN-1:PIX_W];
      s1_ctl_r <= ctl_nxt;
      s1_eoi_r <= img_end;
      s1_col_r <= col_r;
      s1_fwd_r <= fwd_nxt;
    end
  end

  // previous row line buffer
  mprc_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_row_store (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_col_r),
    .wdata (pix),
    .re    (in_acc),
    .raddr (col_r),
    .rdata (ram_rdata)
  );

  assign up = s1_fwd_r ? left_r : ram_rdata;

  // per-channel datapaths
  for (genvar k = 0; k < NCHAN; k++) begin : g_chan
    mprc_chan u_chan (
      .ctl      (s1_ctl_r),
      .x        (s1_x_r[k*CHAN_W +: CHAN_W]),
      .sign_in  (s1_sin_r[k]),
      .nb_left  (left_r[k*CHAN_W +: CHAN_W]),
      .nb_up    (up[k*CHAN_W +: CHAN_W]),
      .nb_ul    (ul_r[k*CHAN_W +: CHAN_W]),
      .res      (res[k*CHAN_W +: CHAN_W]),
      .sign_out (signs[k]),
      .pix      (pix[k*CHAN_W +: CHAN_W])
    );
  end

  // neighbor registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= '0;
      ul_r   <= '0;
    end else if (s1_adv) begin
      left_r <= pix;
      ul_r   <= up;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r <= {4'd0, signs, res};
      out_last_r <= s1_eoi_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  // a new item never lands on a compute stage item that is still held
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> (!s1_valid_r || s1_adv))
    else $error("compute stage overwritten");

  // the column counter stays inside the line buffer
  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    WW'(col_r) < WW'(MAX_WIDTH))
    else $error("column counter out of range");

  // the last pixel of an image sends the counters back to the first pixel
  a_image_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && img_end) |=> (col_r == '0 && row_r == '0 && s1_eoi_r))
    else $error("counters did not wrap at end of image");

  // nothing is offered right after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (!out_valid_r && !s1_valid_r))
    else $error("valid after reset");
`endif

endmodule

/* verif/med_predictor_residual_codec_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// med_predictor_residual_codec_tb
// Checks the RGBA residual codec against a cycle-free predictor of its own.
// Directed images cover the raw first pixel, the left, up and median edge
// predictions, sign handling and decode wrap-around, then the size extremes
// and register changes in the middle of an image. Random images follow,
// under several idling profiles on the input and result streams.
// ----------------------------------------------------------------------------
module med_predictor_residual_codec_tb
  import mprc_pkg::*;
();

  localparam int CLK_HALF      = 10;
  localparam int RESET_CYCLES  = 2;
  localparam int DRAIN_CYCLES  = 4;
  localparam int SETTLE_CYCLES = 8;
  localparam int STALL_LIMIT   = 3000;
  localparam int RANDOM_ITEMS  = 1500;
  localparam int MAX_REPORTS   = 10;

  typedef enum logic {
    PRED_LEFT_UP = 1'b0,
    PRED_MED     = 1'b1
  } pred_mode_t;

  typedef enum logic {
    DIR_ENCODE = 1'b0,
    DIR_DECODE = 1'b1
  } codec_dir_t;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_prof_t;

  // channel 0 (red) in the lowest bits
  typedef logic [NCHAN-1:0][CHAN_W-1:0] chan_vec_t;

  typedef struct packed {
    logic [3:0]       pad;
    logic [NCHAN-1:0] sign_bits;
    chan_vec_t        chans;
  } in_word_t;

  typedef struct packed {
    logic [3:0]       pad;
    logic [NCHAN-1:0] signs;
    chan_vec_t        chans;
  } res_word_t;

  typedef struct packed {
    logic      eoi;
    res_word_t word;
  } pixel_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;   // value_r, value_g, value_b, value_a, sign_bits, 4'b0
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;  // out_r, out_g, out_b, out_a, out_signs, 4'b0
  logic        out_tlast;  // end_of_image
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [3:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  med_predictor_residual_codec i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // predictor state: line store, neighbors, raster position, registers
  logic [PIX_W-1:0]   line_row [MAX_WIDTH];
  logic [PIX_W-1:0]   west_px;
  logic [PIX_W-1:0]   northwest_px;
  int                 col_pos;
  int                 row_pos;
  pred_mode_t         cur_mode;
  codec_dir_t         cur_dir;
  logic [IMG_W_W-1:0] cur_width;
  logic [IMG_H_W-1:0] cur_height;

  pixel_result_t pending_pixels [$];
  int            err_count;
  int            pixels_sent;
  int            gap_pct;
  int            stall_pct;
  int            quiet_cycles;
  string         chan_name [NCHAN] = '{"r", "g", "b", "a"};

  // clock
  always #CLK_HALF clk = ~clk;

  function automatic void note_error(input string msg);
    err_count++;
    if (err_count <= MAX_REPORTS) $display("%s", msg);
  endfunction

  function automatic chan_vec_t rgba(input int r, input int g, input int b, input int a);
    chan_vec_t v;
    v[0] = CHAN_W'(r);
    v[1] = CHAN_W'(g);
    v[2] = CHAN_W'(b);
    v[3] = CHAN_W'(a);
    return v;
  endfunction

  // channel values biased toward both ends of the range
  function automatic chan_vec_t random_chans();
    chan_vec_t v;
    for (int k = 0; k < NCHAN; k++) begin
      case ($urandom_range(3))
        0:       v[k] = CHAN_W'($urandom_range(0, 3));
        1:       v[k] = CHAN_W'($urandom_range(252, 255));
        default: v[k] = CHAN_W'($urandom_range(0, 255));
      endcase
    end
    return v;
  endfunction

  // expected result of one accepted item, then advance the raster state
  function automatic void predict_pixel(input in_word_t item);
    pixel_result_t    res;
    logic [PIX_W-1:0] up_px;
    logic [PIX_W-1:0] kept_px;
    logic [CHAN_W-1:0] x, p, a, b, c, hi, lo;
    int               w, h, ci;
    w = (cur_width == 0) ? 1 : int'(cur_width);
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    h = (cur_height == 0) ? 1 : int'(cur_height);
    ci = (col_pos < MAX_WIDTH) ? col_pos : MAX_WIDTH - 1;
    up_px = line_row[ci];
    res = '0;
    kept_px = '0;
    for (int k = 0; k < NCHAN; k++) begin
      x = item.chans[k];
      if (row_pos == 0 && col_pos == 0) begin
        // first pixel of the image goes through raw
        res.word.chans[k] = x;
        kept_px[k*CHAN_W +: CHAN_W] = x;
      end else begin
        a = west_px[k*CHAN_W +: CHAN_W];
        b = up_px[k*CHAN_W +: CHAN_W];
        c = northwest_px[k*CHAN_W +: CHAN_W];
        if (col_pos == 0) begin
          p = b;
        end else if (row_pos == 0 || cur_mode == PRED_LEFT_UP) begin
          p = a;
        end else begin
          // median edge detector
          hi = (a > b) ? a : b;
          lo = (a > b) ? b : a;
          if (c >= hi) begin
            p = lo;
          end else if (c <= lo) begin
            p = hi;
          end else begin
            p = a + b - c;
          end
        end
        if (cur_dir == DIR_DECODE) begin
          res.word.chans[k] = item.sign_bits[k] ? p - x : p + x;
          kept_px[k*CHAN_W +: CHAN_W] = res.word.chans[k];
        end else begin
          if (x > p) begin
            res.word.chans[k] = x - p;
          end else begin
            res.word.chans[k] = p - x;
            res.word.signs[k] = 1'b1;
          end
          kept_px[k*CHAN_W +: CHAN_W] = x;
        end
      end
    end
    northwest_px = up_px;
    west_px = kept_px;
    line_row[ci] = kept_px;
    // raster position
    if (col_pos + 1 >= w) begin
      col_pos = 0;
      if (row_pos + 1 >= h) begin
        row_pos = 0;
        res.eoi = 1'b1;
      end else begin
        row_pos = row_pos + 1;
      end
    end else begin
      col_pos = col_pos + 1;
    end
    pending_pixels.push_back(res);
  endfunction

  // result checker
  always @(posedge clk) begin : result_check
    pixel_result_t exp_px;
    res_word_t     got;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (pending_pixels.size() == 0) begin
        note_error($sformatf("result %h (last %b) with nothing expected", out_tdata, out_tlast));
      end else begin
        exp_px = pending_pixels.pop_front();
        for (int k = 0; k < NCHAN; k++) begin
          if (got.chans[k] !== exp_px.word.chans[k])
            note_error($sformatf("out_%s: expected %0d, got %0d", chan_name[k],
                                 exp_px.word.chans[k], got.chans[k]));
        end
        if (got.signs !== exp_px.word.signs)
          note_error($sformatf("out_signs: expected %b, got %b", exp_px.word.signs, got.signs));
        if (got.pad !== 4'b0)
          note_error($sformatf("tdata padding: expected 0, got %b", got.pad));
        if (out_tlast !== exp_px.eoi)
          note_error($sformatf("end_of_image: expected %b, got %b", exp_px.eoi, out_tlast));
      end
    end
  end

  // receiver back-pressure
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  // watchdog on cycles with no transfer on any port
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable && cfg_pready) || !rst_n) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("no transfer for %0d cycles, %0d results outstanding",
               quiet_cycles, pending_pixels.size());
      $display("med_predictor_residual_codec_tb: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic void set_idling(input idle_prof_t prof);
    case (prof)
      IDLE_SENDER:   begin gap_pct = 63; stall_pct = 0;  end
      IDLE_RECEIVER: begin gap_pct = 0;  stall_pct = 63; end
      IDLE_BOTH:     begin gap_pct = 20; stall_pct = 20; end
      default:       begin gap_pct = 0;  stall_pct = 0;  end
    endcase
  endfunction

  // send one item; entered and left just after a falling edge
  task automatic send_pixel(input chan_vec_t chans, input logic [NCHAN-1:0] signs);
    in_word_t item;
    item.pad = '0;
    item.sign_bits = signs;
    item.chans = chans;
    while ($urandom_range(99) < gap_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= item;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_pixel(item);
    pixels_sent++;
    @(negedge clk);
  endtask

  // hold input until every expected result is out and the pipe is empty
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // random pixels until the raster wraps, with the odd pause to empty the pipe
  task automatic run_to_image_end();
    do begin
      send_pixel(random_chans(), NCHAN'($urandom_range(15)));
      if ($urandom_range(63) == 0) wait_drained();
    end while (col_pos != 0 || row_pos != 0);
  endtask

  // register write then read back
  task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
    logic [31:0] rd;
    wait_drained();
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    case (idx)
      REG_MODE:   cur_mode   = pred_mode_t'(value[0]);
      REG_DECODE: cur_dir    = codec_dir_t'(value[0]);
      REG_WIDTH:  cur_width  = value[IMG_W_W-1:0];
      default:    cur_height = value[IMG_H_W-1:0];
    endcase
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
    cfg_psel <= 1'b1;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    rd = cfg_prdata;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (rd !== value)
      note_error($sformatf("register %s read back: expected %h, got %h", idx.name(), value, rd));
  endtask

  task automatic set_image(input pred_mode_t mode, input codec_dir_t dir,
                           input int width, input int height);
    write_reg(REG_MODE, 32'(mode));
    write_reg(REG_DECODE, 32'(dir));
    write_reg(REG_WIDTH, width);
    write_reg(REG_HEIGHT, height);
  endtask

  // 3x3 encode image built to hit each predictor branch, signs ignored
  task automatic test_encode_branches();
    chan_vec_t px [9];
    set_image(PRED_MED, DIR_ENCODE, 3, 3);
    px = '{rgba(0, 255, 128, 7), rgba(255, 0, 128, 8), rgba(10, 20, 30, 40),
           rgba(100, 200, 50, 255), rgba(40, 10, 60, 20), rgba(255, 255, 0, 0),
           rgba(200, 5, 55, 0), rgba(140, 5, 60, 0), rgba(0, 255, 255, 255)};
    for (int i = 0; i < 9; i++) send_pixel(px[i], (i == 0) ? 4'hF : 4'(i));
  endtask

  // 3x3 decode image: large residuals both ways so channels wrap
  task automatic test_decode_wrap();
    chan_vec_t        px [9];
    logic [NCHAN-1:0] sg [9];
    set_image(PRED_MED, DIR_DECODE, 3, 3);
    px = '{rgba(12, 34, 56, 78), rgba(255, 255, 0, 0), rgba(255, 255, 1, 254),
           rgba(0, 128, 255, 1), rgba(200, 7, 0, 255), rgba(3, 250, 128, 129),
           rgba(255, 0, 255, 0), rgba(1, 2, 3, 4), rgba(0, 0, 0, 0)};
    sg = '{4'hF, 4'b1010, 4'b0101, 4'b1100, 4'b0011, 4'hF, 4'h0, 4'b1001, 4'hF};
    for (int i = 0; i < 9; i++) send_pixel(px[i], sg[i]);
  endtask

  // left/up predictor on a 2x2 image
  task automatic test_left_up_mode();
    set_image(PRED_LEFT_UP, DIR_ENCODE, 2, 2);
    send_pixel(rgba(9, 250, 0, 255), 4'h0);
    send_pixel(rgba(255, 250, 1, 0), 4'hF);
    send_pixel(rgba(9, 0, 0, 128), 4'h5);
    send_pixel(rgba(0, 255, 2, 127), 4'hA);
  endtask

  // widths and heights at and beyond their ends
  task automatic test_size_extremes();
    // oversized width keeps the row open, then a narrow width ends it
    set_image(PRED_MED, DIR_ENCODE, 4095, 1);
    repeat (40) send_pixel(random_chans(), NCHAN'($urandom_range(15)));
    write_reg(REG_WIDTH, 2);
    run_to_image_end();
    // tallest image, one column, cut short by a smaller height
    set_image(PRED_MED, DIR_DECODE, 1, 65535);
    repeat (12) send_pixel(random_chans(), NCHAN'($urandom_range(15)));
    write_reg(REG_HEIGHT, 5);
    run_to_image_end();
    // zero sizes act as one: every pixel is a whole image
    set_image(PRED_LEFT_UP, DIR_ENCODE, 0, 0);
    repeat (3) run_to_image_end();
  endtask

  // registers changed with the raster part way through an image
  task automatic test_mid_image_change();
    set_image(PRED_MED, DIR_ENCODE, 8, 4);
    repeat (12) send_pixel(random_chans(), NCHAN'($urandom_range(15)));
    write_reg(REG_WIDTH, 2);
    send_pixel(random_chans(), NCHAN'($urandom_range(15)));
    write_reg(REG_MODE, 32'(PRED_LEFT_UP));
    write_reg(REG_DECODE, 32'(DIR_DECODE));
    repeat (3) send_pixel(random_chans(), NCHAN'($urandom_range(15)));
    write_reg(REG_MODE, 32'(PRED_MED));
    repeat (2) send_pixel(random_chans(), NCHAN'($urandom_range(15)));
    write_reg(REG_HEIGHT, 2);
    run_to_image_end();
  endtask

  // random images under each idling profile
  task automatic test_random_images();
    int start_count;
    int width;
    int height;
    for (int ph = 0; ph < 4; ph++) begin
      set_idling(idle_prof_t'(ph));
      start_count = pixels_sent;
      while (pixels_sent - start_count < RANDOM_ITEMS / 4) begin
        if (pixels_sent == start_count || $urandom_range(1) == 0) begin
          if ($urandom_range(99) < 85) begin
            width  = $urandom_range(1, 24);
            height = $urandom_range(1, 8);
          end else begin
            width  = $urandom_range(25, 160);
            height = $urandom_range(1, 2);
          end
          set_image(pred_mode_t'($urandom_range(1)), codec_dir_t'($urandom_range(1)),
                    width, height);
        end
        run_to_image_end();
      end
    end
    set_idling(IDLE_NONE);
  endtask

  initial begin
    clk          = 1'b0;
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    out_tready   = 1'b0;
    cfg_psel     = 1'b0;
    cfg_penable  = 1'b0;
    cfg_pwrite   = 1'b0;
    cfg_paddr    = '0;
    cfg_pwdata   = '0;
    err_count    = 0;
    pixels_sent  = 0;
    quiet_cycles = 0;
    gap_pct      = 0;
    stall_pct    = 0;
    // predictor state after reset
    foreach (line_row[i]) line_row[i] = '0;
    west_px      = '0;
    northwest_px = '0;
    col_pos      = 0;
    row_pos      = 0;
    cur_mode     = PRED_MED;
    cur_dir      = DIR_ENCODE;
    cur_width    = IMG_W_W'(MAX_WIDTH);
    cur_height   = IMG_H_W'(1);

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_encode_branches();
    test_decode_wrap();
    test_left_up_mode();
    test_size_extremes();
    test_mid_image_change();
    test_random_images();

    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (pending_pixels.size() != 0)
      note_error($sformatf("%0d expected results never came", pending_pixels.size()));
    if (err_count == 0) begin
      $display("med_predictor_residual_codec_tb: done, clean");
    end else begin
      $display("med_predictor_residual_codec_tb: done, errors");
    end
    $finish;
  end

endmodule

/* med_predictor_residual_codec.f */
sv/mprc_pkg.sv
sv/mprc_ram.sv
sv/mprc_chan.sv
sv/med_predictor_residual_codec.sv
verif/med_predictor_residual_codec_tb.sv
